// ----- design/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants and arithmetic helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned DriveWidth = 23;
   localparam int unsigned LimitWidth = 31;
   localparam int unsigned AddrWidth  = 5;

   localparam logic [31:0] DtDefault = 32'd66;
   localparam logic [22:0] DriveMax  = 23'd6553600;

   // register byte addresses
   localparam logic [AddrWidth-1:0] AddrGainP  = 5'd0;
   localparam logic [AddrWidth-1:0] AddrGainI  = 5'd4;
   localparam logic [AddrWidth-1:0] AddrGainD  = 5'd8;
   localparam logic [AddrWidth-1:0] AddrEnP    = 5'd12;
   localparam logic [AddrWidth-1:0] AddrEnD    = 5'd16;
   localparam logic [AddrWidth-1:0] AddrLimit  = 5'd20;

   // multiplier operand select
   typedef enum logic [1:0] {
      MUL_P  = 2'd0,
      MUL_GI = 2'd1,
      MUL_DT = 2'd2,
      MUL_D  = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;      // capture input item
      logic        mul_go;    // register one product
      mul_sel_type mul_sel;
      logic        div_start;
      logic        div_step;
      logic        int_add;   // integral += inc, clamp
      logic        finish;    // form drive, back-calc, update memory
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)       sat32 = 32'sh7fffffff;
      else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
      else                           sat32 = v[31:0];
   endfunction

   function automatic logic signed [31:0] clamp_sym(input logic signed [33:0] v,
                                                    input logic [30:0] lim);
      logic signed [33:0] l;
      l = {3'b000, lim};
      if (v > l)       clamp_sym = l[31:0];
      else if (v < -l) clamp_sym = -l[31:0];
      else             clamp_sym = v[31:0];
   endfunction

endpackage

// ----- design/pidaw_if.sv -----
// ----------------------------------------------------------------------------
// pidaw_req_if / pidaw_rsp_if
// Valid/ready channels of the PID controller.
// ----------------------------------------------------------------------------
interface pidaw_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] setpoint;
   logic signed [31:0] measurement;
   logic [31:0]        step_time;
   logic               integral_on;
   modport source (output valid, setpoint, measurement, step_time, integral_on,
                   input ready);
   modport sink   (input valid, setpoint, measurement, step_time, integral_on,
                   output ready);
endinterface

interface pidaw_rsp_if;
   logic        valid;
   logic        ready;
   logic [22:0] drive;
   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

// ----- design/pidaw_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidaw_ctrl
// Sequencer: steps the shared multiplier and the serial divider.
// ----------------------------------------------------------------------------
module pidaw_ctrl
   import pidaw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MP   = 9'b000000010,
      ST_MGI  = 9'b000000100,
      ST_MDT  = 9'b000001000,
      ST_IADD = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_MD   = 9'b001000000,
      ST_FIN  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MP;
            end
         end
         ST_MP: begin
            cmd.mul_go = 1'b1; cmd.mul_sel = MUL_P; state_in = ST_MGI;
         end
         ST_MGI: begin
            cmd.mul_go = 1'b1; cmd.mul_sel = MUL_GI; state_in = ST_MDT;
         end
         ST_MDT: begin
            cmd.mul_go = 1'b1; cmd.mul_sel = MUL_DT; state_in = ST_IADD;
         end
         ST_IADD: begin
            cmd.int_add = 1'b1; cmd.div_start = 1'b1; state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_MD;
         end
         ST_MD: begin
            cmd.mul_go = 1'b1; cmd.mul_sel = MUL_D; state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1; state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);

`ifndef SYNTH
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   a_noaccept: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !in_ready) else $error("accept while busy");
`endif

endmodule

// ----- design/pidaw_dpath.sv -----
// ----------------------------------------------------------------------------
// pidaw_dpath
// Registers, shared 32x33 multiplier and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module pidaw_dpath
   import pidaw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic signed [31:0] setpoint,
   input  logic signed [31:0] measurement,
   input  logic [31:0]        step_time,
   input  logic               integral_on,
   input  logic [31:0]        gain_p,
   input  logic [31:0]        gain_i,
   input  logic [31:0]        gain_d,
   input  logic               enable_p,
   input  logic               enable_d,
   input  logic [30:0]        integral_limit,
   output logic [22:0]        drive
);

   logic signed [31:0] err_ff, pv_ff, pterm_ff, gie_ff, inc_ff, dterm_ff;
   logic signed [31:0] integ_ff, last_ff;
   logic [31:0]        dt_ff;
   logic               ion_ff;
   logic [22:0]        drive_ff;
   // divider: |diff|<<16 needs 49 bits
   logic [48:0]        quo_ff, rem_ff;
   logic [5:0]         cnt_ff;
   logic               neg_ff;

   logic signed [32:0] diff;
   logic [31:0]        mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod;
   logic signed [31:0] qres;
   logic signed [31:0] rate;
   logic [49:0]        rem_sh;
   logic [49:0]        rem_sub;
   logic signed [49:0] rate_w;
   logic signed [33:0] raw;
   logic signed [33:0] excess;
   logic signed [33:0] iterm;

   assign diff = 33'(setpoint) - 33'(measurement);

   // signed rate from magnitude quotient
   assign rate_w = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign rate   = sat32(66'(rate_w));

   always_comb begin
      case (cmd.mul_sel)
         MUL_P:   begin mul_a = gain_p; mul_b = 33'(err_ff); end
         MUL_GI:  begin mul_a = gain_i; mul_b = 33'(err_ff); end
         MUL_DT:  begin mul_a = dt_ff;  mul_b = 33'(gie_ff); end
         default: begin mul_a = gain_d; mul_b = 33'(rate);   end
      endcase
      prod = $signed({34'd0, mul_a}) * 66'(mul_b);
      qres = sat32(prod >>> 16);
   end

   assign rem_sh  = {rem_ff, quo_ff[48]};
   assign rem_sub = rem_sh - {18'd0, dt_ff};

   assign iterm  = ion_ff ? 34'(integ_ff) : 34'sd0;
   assign raw    = 34'(pterm_ff) + iterm + 34'(dterm_ff);
   always_comb begin
      if (raw < 34'sd0)                      excess = raw;
      else if (raw > $signed({11'd0, DriveMax})) excess = raw - $signed({11'd0, DriveMax});
      else                                   excess = 34'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.load) begin
            err_ff   <= sat32(66'(diff));
            pv_ff    <= measurement;
            dt_ff    <= (step_time == 32'd0) ? DtDefault : step_time;
            ion_ff   <= integral_on;
            pterm_ff <= '0;
            dterm_ff <= '0;
         end
         if (cmd.mul_go) begin
            case (cmd.mul_sel)
               MUL_P:   pterm_ff <= enable_p ? qres : 32'sd0;
               MUL_GI:  gie_ff   <= qres;
               MUL_DT:  inc_ff   <= qres;
               default: dterm_ff <= enable_d ? sat32(-66'(qres)) : 32'sd0;
            endcase
         end
         if (cmd.int_add && ion_ff)
            integ_ff <= clamp_sym(34'(integ_ff) + 34'(inc_ff), integral_limit);
         if (cmd.div_start) begin
            // dividend is |pv - last| scaled by 2^16
            neg_ff <= (pv_ff < last_ff);
            quo_ff <= {(pv_ff < last_ff) ? 33'(33'(last_ff) - 33'(pv_ff))
                                         : 33'(33'(pv_ff) - 33'(last_ff)),
                       16'd0};
            rem_ff <= '0;
            cnt_ff <= 6'd49;
         end else if (cmd.div_step && cnt_ff != 6'd0) begin
            if (!rem_sub[49]) begin
               rem_ff <= rem_sub[48:0];
               quo_ff <= {quo_ff[47:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[48:0];
               quo_ff <= {quo_ff[47:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
         end
         if (cmd.finish) begin
            drive_ff <= (raw < 34'sd0) ? 23'd0 :
                        (raw > $signed({11'd0, DriveMax})) ? DriveMax : raw[22:0];
            if (ion_ff)
               integ_ff <= clamp_sym(34'(integ_ff) - excess, integral_limit);
            last_ff <= pv_ff;
         end
      end
   end

   assign sts.div_done = cmd.div_step && (cnt_ff == 6'd1);
   assign drive        = drive_ff;

endmodule

// ----- design/pidaw_csr.sv -----
// ----------------------------------------------------------------------------
// pidaw_csr
// APB register file for gains, enables and integral limit.
// ----------------------------------------------------------------------------
module pidaw_csr
   import pidaw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output logic [31:0]          gain_p,
   output logic [31:0]          gain_i,
   output logic [31:0]          gain_d,
   output logic                 enable_p,
   output logic                 enable_d,
   output logic [30:0]          integral_limit
);

   logic [31:0] gp_ff, gi_ff, gd_ff;
   logic        ep_ff, ed_ff;
   logic [30:0] lim_ff;
   logic        wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff  <= 32'd65536;
         gi_ff  <= '0;
         gd_ff  <= '0;
         ep_ff  <= 1'b1;
         ed_ff  <= 1'b0;
         lim_ff <= 31'd6553600;
      end else if (wr) begin
         unique case (paddr)
            AddrGainP: gp_ff  <= pwdata;
            AddrGainI: gi_ff  <= pwdata;
            AddrGainD: gd_ff  <= pwdata;
            AddrEnP:   ep_ff  <= pwdata[0];
            AddrEnD:   ed_ff  <= pwdata[0];
            AddrLimit: lim_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         AddrGainP: prdata = gp_ff;
         AddrGainI: prdata = gi_ff;
         AddrGainD: prdata = gd_ff;
         AddrEnP:   prdata = {31'd0, ep_ff};
         AddrEnD:   prdata = {31'd0, ed_ff};
         AddrLimit: prdata = {1'b0, lim_ff};
         default:   prdata = '0;
      endcase
   end

   assign gain_p = gp_ff;
   assign gain_i = gi_ff;
   assign gain_d = gd_ff;
   assign enable_p = ep_ff;
   assign enable_d = ed_ff;
   assign integral_limit = lim_ff;

endmodule

// ----- design/pid_controller_antiwindup.sv -----
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Q16.16 PID controller with clamped integral and back-calculation.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transfer per control step (setpoint, measurement,
//    step_time, integral_on). A zero step_time counts as 66 (about 1 ms).
//  - rsp channel: one transfer per step carrying drive in 0..100 (Q16.16).
//  - csr port: APB writes to gains, enables and integral limit; write only
//    while no step is in flight.
// One step at a time: a new request is taken only after the rsp
// transfer of the last one, once the sequencer is back in idle.
// The radix-2 divider forming the measurement rate runs 49
// iterations; four products share one 32x33 multiplier.
// Reset clears the integral sum, the stored measurement and the
// registers to their defaults. While rsp is stalled the result holds
// and no new request is taken.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
   import pidaw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   pidaw_req_if.sink            req,
   pidaw_rsp_if.source          rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] gain_p, gain_i, gain_d;
   logic        enable_p, enable_d;
   logic [30:0] integral_limit;

   // register file
   pidaw_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready),
      .gain_p, .gain_i, .gain_d, .enable_p, .enable_d, .integral_limit
   );

   // sequencer
   pidaw_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd, .sts
   );

   // arithmetic
   pidaw_dpath u_dpath (
      .clock, .reset, .cmd, .sts,
      .setpoint(req.setpoint), .measurement(req.measurement),
      .step_time(req.step_time), .integral_on(req.integral_on),
      .gain_p, .gain_i, .gain_d, .enable_p, .enable_d, .integral_limit,
      .drive(rsp.drive)
   );

endmodule
